FILE: rtl/core/hrc_pkg.sv
// Shared types, constants and Hamming(7,4) helpers for the repetition codec.
`timescale 1ns / 1ps

package hrc_pkg;

  // Repetition degree register
  localparam int unsigned DEG_W = 4;
  localparam logic [DEG_W-1:0] MAX_DEGREE   = 4'd15;
  localparam logic [DEG_W-1:0] DEGREE_RESET = 4'd3;

  // Nibble mask and Hamming bits per message byte and per codeword
  localparam logic [3:0] NIB_MASK = 4'hF;
  localparam logic [3:0] HBITS_PER_BYTE = 4'd14;
  localparam logic [3:0] HBITS_PER_CW   = 4'd7;

  // Input beat
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       msg_last;
  } hrc_in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_end;
  } hrc_out_t;

  // Classified item handed from the front to the back
  typedef enum logic {
    JOB_ENC = 1'b0,
    JOB_DEC = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } hrc_job_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_BITS,
    ST_ENC_PAD,
    ST_DEC_BITS,
    ST_DEC_FLUSH,
    ST_DEC_PAD,
    ST_TAIL,
    ST_FIN
  } back_state_t;

  // Clamp the configured degree into 1..MAX_DEGREE
  function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] cfg);
    logic [DEG_W-1:0] n;
    n = cfg;
    if (n == '0) n = {{(DEG_W-1){1'b0}}, 1'b1};
    if (n > MAX_DEGREE) n = MAX_DEGREE;
    return n;
  endfunction

  // Codeword order p1 p2 d1 p3 d2 d3 d4, MSB first
  function automatic logic [6:0] hamming_encode(input logic [3:0] nib);
    logic d1, d2, d3, d4;
    d1 = nib[3];
    d2 = nib[2];
    d3 = nib[1];
    d4 = nib[0];
    return {d1 ^ d2 ^ d4, d1 ^ d3 ^ d4, d1, d2 ^ d3 ^ d4, d2, d3, d4};
  endfunction

  // Correct a single error and pull out the data nibble
  function automatic logic [3:0] hamming_decode(input logic [6:0] cw);
    logic [2:0] syn;
    logic [6:0] flip;
    logic [6:0] fixed;
    syn   = {cw[3] ^ cw[2] ^ cw[1] ^ cw[0],
             cw[5] ^ cw[4] ^ cw[1] ^ cw[0],
             cw[6] ^ cw[4] ^ cw[2] ^ cw[0]};
    flip  = (syn == 3'd0) ? 7'd0 : (7'b1000000 >> (syn - 3'd1));
    fixed = cw ^ flip;
    return {fixed[4], fixed[2], fixed[1], fixed[0]} & NIB_MASK;
  endfunction

endpackage

FILE: rtl/core/hrc_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module hrc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  hrc_pkg::hrc_in_t  in_data,
  output logic              job_valid,
  output hrc_pkg::hrc_job_t job,
  input  logic              job_take
);

  hrc_pkg::hrc_job_t slot_r [2];
  hrc_pkg::hrc_job_t job_in;
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              acc;
  logic              take;

  assign in_full   = (count_r == 2'd2);
  assign job_valid = (count_r != 2'd0);
  assign job       = slot_r[rd_ptr_r];
  assign acc       = in_push && !in_full;
  assign take      = job_take && job_valid;

  // Classify the incoming beat
  always_comb begin
    job_in.kind = in_data.cmd ? hrc_pkg::JOB_DEC : hrc_pkg::JOB_ENC;
    job_in.data = in_data.data_byte;
    job_in.last = in_data.msg_last;
  end

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (acc) wr_ptr_r <= !wr_ptr_r;
      if (take) rd_ptr_r <= !rd_ptr_r;
      case ({acc, take})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the accepted beat
  always_ff @(posedge clk) begin
    if (acc) slot_r[wr_ptr_r] <= job_in;
  end

endmodule

FILE: rtl/core/hrc_outq.sv
// Result queue: two-entry buffer between the back end and the result channel.
`timescale 1ns / 1ps

module hrc_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrc_pkg::hrc_out_t push_data,
  output logic              outq_full,
  output logic              out_empty,
  input  logic              out_pop,
  output hrc_pkg::hrc_out_t out_data
);

  hrc_pkg::hrc_out_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              acc;
  logic              take;

  assign outq_full = (count_r == 2'd2);
  assign out_empty = (count_r == 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign acc       = push && !outq_full;
  assign take      = out_pop && !out_empty;

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (acc) wr_ptr_r <= !wr_ptr_r;
      if (take) rd_ptr_r <= !rd_ptr_r;
      case ({acc, take})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store the pushed result
  always_ff @(posedge clk) begin
    if (acc) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/core/hrc_back.sv
// Back end: encode/decode sequencer that turns queued items into result bytes.
`timescale 1ns / 1ps

module hrc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hrc_pkg::DEG_W-1:0] cfg_degree,
  input  logic                      job_valid,
  input  hrc_pkg::hrc_job_t         job,
  output logic                      job_take,
  output logic                      push,
  output hrc_pkg::hrc_out_t         push_data,
  input  logic                      outq_full
);

  hrc_pkg::back_state_t state_r, state_nxt;
  hrc_pkg::back_state_t first_state;
  hrc_pkg::hrc_job_t    job_r, job_nxt;

  logic [3:0] hbit_r, hbit_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [2:0] dbit_r, dbit_nxt;
  logic [7:0] pack_bits_r, pack_bits_nxt;
  logic [2:0] pack_count_r, pack_count_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [3:0] vote_ones_r, vote_ones_nxt;
  logic [3:0] vote_pos_r, vote_pos_nxt;
  logic [6:0] cw_bits_r, cw_bits_nxt;
  logic [2:0] cw_count_r, cw_count_nxt;
  logic [4:0] held_r, held_nxt;
  logic [7:0] pend_r;
  logic       pend_v_r;

  logic [hrc_pkg::DEG_W-1:0] n_deg;
  logic [hrc_pkg::DEG_W-1:0] half;

  // Encoder bit source and repetition packing
  logic [3:0]  enc_nib;
  logic [6:0]  enc_cw;
  logic [2:0]  cw_idx;
  logic        enc_bit;
  logic [3:0]  space;
  logic [3:0]  take;
  logic [15:0] shifted;
  logic [7:0]  fill;
  logic [7:0]  rep_bits;
  logic        rep_full;
  logic [3:0]  rem_left;
  logic        bit_done;

  // Decoder vote and codeword step
  logic        dec_in_bit;
  logic [3:0]  ones_sum;
  logic [3:0]  pos_sum;
  logic        group_close;
  logic        vote_v;
  logic        flush_v;
  logic        cw_go;
  logic        cw_in;
  logic [6:0]  cw_next;
  logic [2:0]  cw_cnt_next;
  logic        cw_full;
  logic [3:0]  dec_nib;

  logic        emit_v;
  logic [7:0]  emit_byte;
  logic        release_pend;
  logic        stall;

  assign n_deg = hrc_pkg::eff_degree(cfg_degree);
  assign half  = n_deg >> 1;

  // Pick the current Hamming bit of the item
  assign enc_nib = (hbit_r < hrc_pkg::HBITS_PER_CW) ? job_r.data[7:4] : job_r.data[3:0];
  assign cw_idx  = (hbit_r < hrc_pkg::HBITS_PER_CW) ? hbit_r[2:0]
                                                     : 3'(hbit_r - hrc_pkg::HBITS_PER_CW);
  assign enc_cw  = hrc_pkg::hamming_encode(enc_nib);
  assign enc_bit = (state_r == hrc_pkg::ST_ENC_BITS) ? enc_cw[3'd6 - cw_idx] : 1'b0;

  // Place as many copies of the bit as fit in the byte being filled
  assign space    = 4'd8 - {1'b0, pack_count_r};
  assign take     = (rem_r < space) ? rem_r : space;
  assign shifted  = {8'd0, pack_bits_r} << take;
  assign fill     = enc_bit ? (8'hFF >> (4'd8 - take)) : 8'h00;
  assign rep_bits = shifted[7:0] | fill;
  assign rep_full = (({1'b0, pack_count_r} + take) == 4'd8);
  assign rem_left = rem_r - take;
  assign bit_done = (rem_left == 4'd0);

  // Count votes for one received bit
  assign dec_in_bit  = job_r.data[3'd7 - dbit_r];
  assign ones_sum    = vote_ones_r + {3'd0, dec_in_bit};
  assign pos_sum     = vote_pos_r + 4'd1;
  assign group_close = (pos_sum >= n_deg);
  assign vote_v      = (ones_sum > half);
  assign flush_v     = (vote_ones_r > half);

  // Select the voted bit that enters the codeword this cycle
  always_comb begin
    cw_go = 1'b0;
    cw_in = 1'b0;
    case (state_r)
      hrc_pkg::ST_DEC_BITS: begin
        cw_go = group_close;
        cw_in = vote_v;
      end
      hrc_pkg::ST_DEC_FLUSH: begin
        cw_go = (vote_pos_r != 4'd0);
        cw_in = flush_v;
      end
      hrc_pkg::ST_DEC_PAD: begin
        cw_go = (phase_r != 3'd0);
        cw_in = 1'b0;
      end
      default: begin
        cw_go = 1'b0;
        cw_in = 1'b0;
      end
    endcase
  end

  assign cw_next     = {cw_bits_r[5:0], cw_in};
  assign cw_cnt_next = cw_count_r + 3'd1;
  assign cw_full     = (cw_cnt_next == 3'(hrc_pkg::HBITS_PER_CW));
  assign dec_nib     = hrc_pkg::hamming_decode(cw_next);

  assign first_state = (job.kind == hrc_pkg::JOB_DEC) ? hrc_pkg::ST_DEC_BITS
                                                      : hrc_pkg::ST_ENC_BITS;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrc_pkg::ST_IDLE: begin
        if (job_valid) state_nxt = first_state;
      end
      hrc_pkg::ST_ENC_BITS: begin
        if (bit_done && (hbit_r == hrc_pkg::HBITS_PER_BYTE - 4'd1)) begin
          state_nxt = job_r.last ? hrc_pkg::ST_ENC_PAD : hrc_pkg::ST_FIN;
        end
      end
      hrc_pkg::ST_ENC_PAD: begin
        if (phase_r == 3'd0) state_nxt = hrc_pkg::ST_TAIL;
      end
      hrc_pkg::ST_DEC_BITS: begin
        if (dbit_r == 3'd7) begin
          state_nxt = job_r.last ? hrc_pkg::ST_DEC_FLUSH : hrc_pkg::ST_FIN;
        end
      end
      hrc_pkg::ST_DEC_FLUSH: begin
        state_nxt = hrc_pkg::ST_DEC_PAD;
      end
      hrc_pkg::ST_DEC_PAD: begin
        if (phase_r == 3'd0) state_nxt = hrc_pkg::ST_TAIL;
      end
      hrc_pkg::ST_TAIL: begin
        state_nxt = hrc_pkg::ST_FIN;
      end
      hrc_pkg::ST_FIN: begin
        state_nxt = job_valid ? first_state : hrc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hrc_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath updates and emitted byte
  always_comb begin
    job_nxt        = job_r;
    hbit_nxt       = hbit_r;
    rem_nxt        = rem_r;
    dbit_nxt       = dbit_r;
    pack_bits_nxt  = pack_bits_r;
    pack_count_nxt = pack_count_r;
    phase_nxt      = phase_r;
    vote_ones_nxt  = vote_ones_r;
    vote_pos_nxt   = vote_pos_r;
    cw_bits_nxt    = cw_bits_r;
    cw_count_nxt   = cw_count_r;
    held_nxt       = held_r;
    emit_v         = 1'b0;
    emit_byte      = 8'd0;

    // Load a new item
    if ((state_r == hrc_pkg::ST_IDLE) || (state_r == hrc_pkg::ST_FIN)) begin
      if (job_valid) begin
        job_nxt  = job;
        hbit_nxt = 4'd0;
        dbit_nxt = 3'd0;
        rem_nxt  = n_deg;
      end
    end

    // Repeat Hamming bits into output bytes
    if ((state_r == hrc_pkg::ST_ENC_BITS) ||
        ((state_r == hrc_pkg::ST_ENC_PAD) && (phase_r != 3'd0))) begin
      if (rep_full) begin
        emit_v         = 1'b1;
        emit_byte      = rep_bits;
        pack_bits_nxt  = 8'd0;
        pack_count_nxt = 3'd0;
      end else begin
        pack_bits_nxt  = rep_bits;
        pack_count_nxt = 3'({1'b0, pack_count_r} + take);
      end
      if (bit_done) begin
        rem_nxt   = n_deg;
        phase_nxt = phase_r + 3'd1;
        hbit_nxt  = hbit_r + 4'd1;
      end else begin
        rem_nxt = rem_left;
      end
    end

    // Accumulate votes over received bits
    if (state_r == hrc_pkg::ST_DEC_BITS) begin
      dbit_nxt = dbit_r + 3'd1;
      if (group_close) begin
        vote_ones_nxt = 4'd0;
        vote_pos_nxt  = 4'd0;
      end else begin
        vote_ones_nxt = ones_sum;
        vote_pos_nxt  = pos_sum;
      end
    end

    // Close a partial vote group at message end
    if (state_r == hrc_pkg::ST_DEC_FLUSH) begin
      vote_ones_nxt = 4'd0;
      vote_pos_nxt  = 4'd0;
    end

    // Shift a voted bit into the codeword, correct and pair nibbles
    if (cw_go) begin
      phase_nxt = phase_r + 3'd1;
      if (cw_full) begin
        cw_bits_nxt  = 7'd0;
        cw_count_nxt = 3'd0;
        if (held_r[4]) begin
          emit_v    = 1'b1;
          emit_byte = {held_r[3:0], dec_nib};
          held_nxt  = 5'd0;
        end else begin
          held_nxt = {1'b1, dec_nib};
        end
      end else begin
        cw_bits_nxt  = cw_next;
        cw_count_nxt = cw_cnt_next;
      end
    end

    // Flush the partial byte and clear the stream at message end
    if (state_r == hrc_pkg::ST_TAIL) begin
      if (job_r.kind == hrc_pkg::JOB_ENC) begin
        if (pack_count_r != 3'd0) begin
          emit_v    = 1'b1;
          emit_byte = 8'(pack_bits_r << (4'd8 - {1'b0, pack_count_r}));
        end
      end else begin
        if (held_r[4]) begin
          emit_v    = 1'b1;
          emit_byte = {held_r[3:0], 4'd0};
        end
      end
      pack_bits_nxt  = 8'd0;
      pack_count_nxt = 3'd0;
      phase_nxt      = 3'd0;
      vote_ones_nxt  = 4'd0;
      vote_pos_nxt   = 4'd0;
      cw_bits_nxt    = 7'd0;
      cw_count_nxt   = 3'd0;
      held_nxt       = 5'd0;
    end
  end

  // Hold back one byte so the final byte of an item can be marked
  assign release_pend = pend_v_r && (emit_v || (state_r == hrc_pkg::ST_FIN));
  assign stall        = release_pend && outq_full;
  assign push         = release_pend && !outq_full;
  assign job_take     = job_valid && !stall &&
                        ((state_r == hrc_pkg::ST_IDLE) || (state_r == hrc_pkg::ST_FIN));

  always_comb begin
    push_data.out_byte = pend_r;
    push_data.run_last = (state_r == hrc_pkg::ST_FIN);
    push_data.msg_end  = (state_r == hrc_pkg::ST_FIN) && job_r.last;
  end

  // Advance sequencer unless the result queue blocks a release
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hrc_pkg::ST_IDLE;
      pend_v_r     <= 1'b0;
      pack_bits_r  <= 8'd0;
      pack_count_r <= 3'd0;
      phase_r      <= 3'd0;
      vote_ones_r  <= 4'd0;
      vote_pos_r   <= 4'd0;
      cw_bits_r    <= 7'd0;
      cw_count_r   <= 3'd0;
      held_r       <= 5'd0;
      hbit_r       <= 4'd0;
      rem_r        <= 4'd0;
      dbit_r       <= 3'd0;
    end else if (!stall) begin
      state_r      <= state_nxt;
      pack_bits_r  <= pack_bits_nxt;
      pack_count_r <= pack_count_nxt;
      phase_r      <= phase_nxt;
      vote_ones_r  <= vote_ones_nxt;
      vote_pos_r   <= vote_pos_nxt;
      cw_bits_r    <= cw_bits_nxt;
      cw_count_r   <= cw_count_nxt;
      held_r       <= held_nxt;
      hbit_r       <= hbit_nxt;
      rem_r        <= rem_nxt;
      dbit_r       <= dbit_nxt;
      if (emit_v) begin
        pend_v_r <= 1'b1;
      end else if (state_r == hrc_pkg::ST_FIN) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Item and held byte payload
  always_ff @(posedge clk) begin
    if (!stall) begin
      job_r <= job_nxt;
      if (emit_v) pend_r <= emit_byte;
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !outq_full)
    else $error("result pushed into a full queue");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == hrc_pkg::ST_ENC_BITS) || (state_r == hrc_pkg::ST_ENC_PAD)) |-> (rem_r != 4'd0))
    else $error("repeat count ran out inside a Hamming bit");

  a_cw_short: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |-> (cw_count_r < 3'(hrc_pkg::HBITS_PER_CW)))
    else $error("full codeword left undecoded");

  a_msg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == hrc_pkg::ST_FIN) && job_r.last) |->
      ((phase_r == 3'd0) && (pack_count_r == 3'd0) && (held_r == 5'd0) &&
       (vote_pos_r == 4'd0)))
    else $error("stream state not cleared at message end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(pend_r) && pend_v_r)
    else $error("held byte changed while blocked");
`endif

endmodule

FILE: rtl/core/hamming_repetition_codec.sv
// Top level of the Hamming(7,4) plus repetition streaming codec.
//
// Usage: bytes enter on the in_ channel (push while full is low); each beat carries
// cmd (0 encode, 1 decode), data_byte and msg_last. Results leave on the out_ channel:
// while out_empty is low, out_data holds the oldest result; pop takes it. run_last
// marks the final result of an input beat, msg_end the final result of a message.
// cfg_we/cfg_wdata set the repetition degree N (0 acts as 1); write it only when idle.
// A two-entry input queue feeds the sequencer, which feeds a two-entry result queue.
// Encode turns each byte into 14 Hamming bits sent N times each (14*N/8 output
// bytes on average), one Hamming bit per cycle while its copies fit in the byte
// being filled and the result queue does not stall; message end adds zero padding
// bits, a step to leave the padding and a tail step. Decode takes one received
// bit per cycle unless the queue stalls; message end adds flush, pad and tail steps.
// A result leaves the sequencer once the next result of the same beat exists or the
// beat is done. Reset (rst_n low at a clock edge) empties both queues, clears the
// stream state and sets N to 3. When the receiver stops popping, the result
// queue fills, the sequencer holds, then the input queue fills and raises
// in_full; nothing is lost.
`timescale 1ns / 1ps

module hamming_repetition_codec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  hrc_pkg::hrc_in_t          in_data,
  output logic                      out_empty,
  input  logic                      out_pop,
  output hrc_pkg::hrc_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [hrc_pkg::DEG_W-1:0] cfg_wdata
);

  logic [hrc_pkg::DEG_W-1:0] degree_r;
  logic                      job_valid;
  hrc_pkg::hrc_job_t         job;
  logic                      job_take;
  logic                      push;
  hrc_pkg::hrc_out_t         push_data;
  logic                      outq_full;

  // Hold the repetition degree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= hrc_pkg::DEGREE_RESET;
    end else if (cfg_we) begin
      degree_r <= cfg_wdata;
    end
  end

  hrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  hrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_degree (degree_r),
    .job_valid  (job_valid),
    .job        (job),
    .job_take   (job_take),
    .push       (push),
    .push_data  (push_data),
    .outq_full  (outq_full)
  );

  hrc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .outq_full (outq_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

FILE: bench/codec_checker.sv
// Checker for the repetition codec: predicts result beats and compares them on pop.
`timescale 1ns / 1ps

module codec_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_full,
  input  hrc_pkg::hrc_in_t          in_data,
  input  logic                      out_empty,
  input  logic                      out_pop,
  input  hrc_pkg::hrc_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [hrc_pkg::DEG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);

  // Predictor copy of the degree register and the stream state
  logic [hrc_pkg::DEG_W-1:0] degree_reg;
  logic [7:0]                pack_acc;
  int                        pack_fill;
  logic [2:0]                hbit_phase;
  int                        vote_sum;
  int                        vote_fill;
  logic [6:0]                cw_acc;
  int                        cw_fill;
  logic [4:0]                nib_hold;

  logic [7:0]        step_bytes[$];
  hrc_pkg::hrc_out_t expected_beats[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] codec_checker: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int repeat_count();
    int n;
    n = int'(degree_reg);
    if (n == 0) n = 1;
    if (n > int'(hrc_pkg::MAX_DEGREE)) n = int'(hrc_pkg::MAX_DEGREE);
    return n;
  endfunction

  function automatic void clear_stream();
    pack_acc   = '0;
    pack_fill  = 0;
    hbit_phase = '0;
    vote_sum   = 0;
    vote_fill  = 0;
    cw_acc     = '0;
    cw_fill    = 0;
    nib_hold   = '0;
  endfunction

  // Send N copies of one Hamming bit into the output byte packer
  function automatic void send_copies(input logic b);
    int n;
    int k;
    n = repeat_count();
    for (k = 0; k < n; k++) begin
      pack_acc = {pack_acc[6:0], b};
      pack_fill++;
      if (pack_fill == 8) begin
        step_bytes.push_back(pack_acc);
        pack_acc  = '0;
        pack_fill = 0;
      end
    end
    hbit_phase = hbit_phase + 3'd1;
  endfunction

  // Build p1 p2 d1 p3 d2 d3 d4 and send it MSB first
  function automatic void encode_nibble(input logic [3:0] nib);
    logic [6:0] cw;
    int i;
    cw = {nib[3] ^ nib[2] ^ nib[0], nib[3] ^ nib[1] ^ nib[0], nib[3],
          nib[2] ^ nib[1] ^ nib[0], nib[2], nib[1], nib[0]};
    for (i = 6; i >= 0; i--) send_copies(cw[i]);
  endfunction

  // Collect one voted bit; on a full codeword correct it and pair the nibbles into bytes
  function automatic void take_voted(input logic v);
    logic [2:0] syn;
    logic [6:0] fixed;
    logic [3:0] nib;
    cw_acc = {cw_acc[5:0], v};
    cw_fill++;
    hbit_phase = hbit_phase + 3'd1;
    if (cw_fill == 7) begin
      fixed = cw_acc;
      syn = {fixed[3] ^ fixed[2] ^ fixed[1] ^ fixed[0],
             fixed[5] ^ fixed[4] ^ fixed[1] ^ fixed[0],
             fixed[6] ^ fixed[4] ^ fixed[2] ^ fixed[0]};
      if (syn != 3'd0) fixed = fixed ^ (7'd1 << (7 - int'(syn)));
      nib = {fixed[4], fixed[2], fixed[1], fixed[0]};
      cw_acc  = '0;
      cw_fill = 0;
      if (nib_hold[4]) begin
        step_bytes.push_back({nib_hold[3:0], nib});
        nib_hold = '0;
      end else begin
        nib_hold = {1'b1, nib};
      end
    end
  endfunction

  function automatic void close_vote(input int n);
    logic v;
    v = (vote_sum > n / 2);
    vote_sum  = 0;
    vote_fill = 0;
    take_voted(v);
  endfunction

  // Work out every result beat caused by one input beat
  function automatic void predict_beat(input hrc_pkg::hrc_in_t beat);
    hrc_pkg::hrc_out_t res;
    int n;
    int i;
    step_bytes.delete();
    if (hrc_pkg::job_kind_t'(beat.cmd) == hrc_pkg::JOB_ENC) begin
      encode_nibble(beat.data_byte[7:4]);
      encode_nibble(beat.data_byte[3:0]);
      if (beat.msg_last) begin
        while (hbit_phase != 3'd0) send_copies(1'b0);
        if (pack_fill != 0) step_bytes.push_back(pack_acc << (8 - pack_fill));
      end
    end else begin
      n = repeat_count();
      for (i = 7; i >= 0; i--) begin
        vote_sum += int'(beat.data_byte[i]);
        vote_fill++;
        if (vote_fill >= n) close_vote(n);
      end
      if (beat.msg_last) begin
        if (vote_fill != 0) close_vote(n);
        while (hbit_phase != 3'd0) take_voted(1'b0);
        if (nib_hold[4]) step_bytes.push_back({nib_hold[3:0], 4'h0});
      end
    end
    if (beat.msg_last) clear_stream();
    for (i = 0; i < step_bytes.size(); i++) begin
      res.out_byte = step_bytes[i];
      res.run_last = (i == step_bytes.size() - 1);
      res.msg_end  = res.run_last && beat.msg_last;
      expected_beats.push_back(res);
    end
  endfunction

  // Track config, predict on accepted input, compare on accepted output
  always @(posedge clk) begin : watch
    hrc_pkg::hrc_out_t want;
    if (!rst_n) begin
      degree_reg = hrc_pkg::DEGREE_RESET;
      clear_stream();
      expected_beats.delete();
    end else begin
      if (cfg_we) degree_reg = cfg_wdata;
      if (in_push && !in_full) predict_beat(in_data);
      if (out_pop && !out_empty) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with nothing expected", out_data.out_byte));
        end else begin
          want = expected_beats.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("beat %0d out_byte got 0x%02h want 0x%02h",
                                      checked, out_data.out_byte, want.out_byte));
          if (out_data.run_last !== want.run_last)
            report_mismatch($sformatf("beat %0d run_last got %b want %b",
                                      checked, out_data.run_last, want.run_last));
          if (out_data.msg_end !== want.msg_end)
            report_mismatch($sformatf("beat %0d msg_end got %b want %b",
                                      checked, out_data.msg_end, want.msg_end));
          checked++;
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

FILE: bench/hamming_repetition_codec_tb.sv
// Testbench top for the repetition codec: clock, reset, stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module hamming_repetition_codec_tb;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int QUIET_CYCLES = 80;
  localparam int LONG_HOLD    = 250;
  localparam int RANDOM_ITEMS = 150;
  localparam int PHASE_ITEMS  = 28;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_MASK, POP_SPARSE} pop_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_push;
  logic                      in_full;
  hrc_pkg::hrc_in_t          in_data;
  logic                      out_empty;
  logic                      out_pop;
  hrc_pkg::hrc_out_t         out_data;
  logic                      cfg_we;
  logic [hrc_pkg::DEG_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;

  int                        cycle_count   = 0;
  int                        items_sent    = 0;
  int                        msgs_sent     = 0;
  int                        burst_left    = 0;
  int                        hold_left     = 0;
  bit                        long_hold_req = 1'b0;
  logic [hrc_pkg::DEG_W-1:0] cur_degree    = hrc_pkg::DEGREE_RESET;

  // Scratch for building coded decode streams
  logic [7:0] msg_buf[$];
  logic       hamming_bits[$];
  logic       line_bits[$];

  always #(CLK_HALF) clk = ~clk;

  hamming_repetition_codec dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  codec_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog: cycle limit reached with %0d results outstanding", pending);
      $display("hamming_repetition_codec_tb: done, errors");
      $finish;
    end
  end

  // Offer one beat in bursts with random gaps; return at the falling edge after accept
  task automatic send_beat(input hrc_pkg::job_kind_t kind, input logic [7:0] b,
                           input logic last);
    hrc_pkg::hrc_in_t beat;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    beat.cmd       = kind;
    beat.data_byte = b;
    beat.msg_last  = last;
    in_push <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    burst_left--;
    if (last) msgs_sent++;
    @(negedge clk);
  endtask

  // Hold input, wait for every expected result, then let the sequencer settle
  task automatic drain();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_degree(input logic [hrc_pkg::DEG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_degree = v;
  endtask

  // Encode msg_buf at the current degree, add noise, and send it as a decode message
  task automatic send_coded(input int flip_at, input int noise_pm, input int keep);
    logic [6:0] cw;
    logic [7:0] acc;
    int n;
    int i;
    int j;
    int k;
    int nbytes;
    n = (cur_degree == 0) ? 1 : int'(cur_degree);
    hamming_bits.delete();
    line_bits.delete();
    for (i = 0; i < msg_buf.size(); i++) begin
      for (k = 0; k < 2; k++) begin
        cw = hrc_pkg::hamming_encode((k == 0) ? msg_buf[i][7:4] : msg_buf[i][3:0]);
        for (j = 6; j >= 0; j--) hamming_bits.push_back(cw[j]);
      end
    end
    while (hamming_bits.size() % 8 != 0) hamming_bits.push_back(1'b0);
    if (flip_at >= 0 && flip_at < hamming_bits.size())
      hamming_bits[flip_at] = ~hamming_bits[flip_at];
    for (i = 0; i < hamming_bits.size(); i++)
      for (k = 0; k < n; k++)
        line_bits.push_back(hamming_bits[i] ^ ($urandom_range(0, 999) < noise_pm));
    while (line_bits.size() % 8 != 0) line_bits.push_back(1'b0);
    nbytes = line_bits.size() / 8;
    if (keep > 0 && keep < nbytes) nbytes = keep;
    for (i = 0; i < nbytes; i++) begin
      acc = '0;
      for (k = 0; k < 8; k++) acc = {acc[6:0], line_bits[i * 8 + k]};
      send_beat(hrc_pkg::JOB_DEC, acc, i == nbytes - 1);
    end
  endtask

  // Receiver: stall pattern of its own, plus one long hold on request
  initial begin : receiver
    pop_mode_t  mode;
    int         span;
    logic [7:0] mask;
    out_pop = 1'b0;
    mode    = POP_ALWAYS;
    span    = 0;
    mask    = 8'hFF;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_left == 0) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = pop_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 80);
          mask = 8'($urandom()) | 8'h01;
        end
        span--;
        case (mode)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
          POP_MASK:   out_pop <= mask[span % 8];
          default:    out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int   degree_plan[7];
    int   directed_items;
    int   phase_start;
    int   ph;
    int   i;
    int   len;
    int   pick;
    bit   big;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset degree, data extremes, multi-byte message
    send_beat(hrc_pkg::JOB_ENC, 8'h00, 1'b1);
    send_beat(hrc_pkg::JOB_ENC, 8'hFF, 1'b1);
    send_beat(hrc_pkg::JOB_ENC, 8'h12, 1'b0);
    send_beat(hrc_pkg::JOB_ENC, 8'h34, 1'b0);
    send_beat(hrc_pkg::JOB_ENC, 8'hEF, 1'b1);

    // Degree one: single-bit error corrected by the syndrome, then raw extremes
    set_degree(4'd1);
    msg_buf.delete();
    msg_buf.push_back(8'hA5);
    send_coded(2, 0, 0);
    send_beat(hrc_pkg::JOB_DEC, 8'h00, 1'b0);
    send_beat(hrc_pkg::JOB_DEC, 8'hFF, 1'b1);

    // Degree zero acts as one
    set_degree(4'd0);
    send_beat(hrc_pkg::JOB_ENC, 8'h3C, 1'b1);

    // Top degree: long encode run, decode with a partial group flushed at the end
    set_degree(hrc_pkg::MAX_DEGREE);
    send_beat(hrc_pkg::JOB_ENC, 8'h81, 1'b1);
    send_beat(hrc_pkg::JOB_DEC, 8'hFF, 1'b0);
    send_beat(hrc_pkg::JOB_DEC, 8'h00, 1'b1);

    // Degree lowered while a vote group is open
    set_degree(4'd3);
    send_beat(hrc_pkg::JOB_DEC, 8'hB6, 1'b0);
    set_degree(4'd2);
    send_beat(hrc_pkg::JOB_DEC, 8'h4D, 1'b1);

    // Command switched mid-message; the closing decode beat yields nothing
    set_degree(hrc_pkg::MAX_DEGREE);
    send_beat(hrc_pkg::JOB_ENC, 8'h5A, 1'b0);
    send_beat(hrc_pkg::JOB_DEC, 8'h00, 1'b1);
    directed_items = items_sent;

    // Random phases over a plan of degrees
    degree_plan[0] = 1;
    degree_plan[1] = 15;
    degree_plan[2] = 0;
    degree_plan[3] = $urandom_range(2, 14);
    degree_plan[4] = 3;
    degree_plan[5] = $urandom_range(4, 12);
    degree_plan[6] = 2;
    ph = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      set_degree(4'(degree_plan[ph % 7]));
      // First phase: receiver holds off while the sender keeps pushing
      if (ph == 0) long_hold_req = 1'b1;
      big = (cur_degree >= 8);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - directed_items < RANDOM_ITEMS) begin
        if (ph == 0 || $urandom_range(0, 1) == 0) begin
          len = $urandom_range(1, big ? 2 : 5);
          for (i = 0; i < len; i++)
            send_beat(hrc_pkg::JOB_ENC, 8'($urandom()), i == len - 1);
        end else begin
          pick = $urandom_range(0, 9);
          msg_buf.delete();
          len = $urandom_range(1, big ? 1 : 3);
          for (i = 0; i < len; i++) msg_buf.push_back(8'($urandom()));
          if (pick <= 5) begin
            send_coded(-1, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 80), 0);
          end else if (pick <= 7) begin
            // Truncated stream: message ends early
            send_coded(-1, 20, $urandom_range(1, 3));
          end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
              send_beat(hrc_pkg::JOB_DEC, 8'($urandom()), i == len - 1);
          end
        end
      end
      ph++;
    end

    drain();
    $display("covered %0d input beats (%0d directed) in %0d messages over %0d degree phases",
             items_sent, directed_items, msgs_sent, ph);
    $display("checked %0d result beats: encode, clean/noisy/truncated decode, long output stall",
             checked);
    if (fail_count == 0) begin
      $display("hamming_repetition_codec_tb: done, clean");
    end else begin
      $display("hamming_repetition_codec_tb: done, errors");
    end
    $finish;
  end

endmodule
